### hdl/skvt_pkg.sv
// Shared constants, types and codes for the small key/value table.
package skvt_pkg;

   localparam int CAPACITY   = 256;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);

   localparam int CMD_FIELD_BITS   = 3;
   localparam int KEY_FIELD_BITS   = 32;
   localparam int VALUE_FIELD_BITS = 32;
   localparam int INDEX_FIELD_BITS = 8;
   localparam int COUNT_FIELD_BITS = 9;

   typedef enum logic [CMD_FIELD_BITS-1:0] {
      CMD_INSERT    = 3'd0,
      CMD_UPDATE    = 3'd1,
      CMD_UPSERT    = 3'd2,
      CMD_ERASE     = 3'd3,
      CMD_GET_KEY   = 3'd4,
      CMD_GET_INDEX = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ERASE_WR,
      ST_INDEX_CAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic                        ok;
      logic [KEY_FIELD_BITS-1:0]   key_out;
      logic [VALUE_FIELD_BITS-1:0] value_out;
      logic [COUNT_FIELD_BITS-1:0] count;
   } result_type;

endpackage

### hdl/skvt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module skvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/skvt_ctrl.sv
// Command sequencer: linear key search, read-modify-write of the slot RAM, entry count.
module skvt_ctrl (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [skvt_pkg::CMD_FIELD_BITS-1:0]     req_command,
   input  logic [skvt_pkg::KEY_FIELD_BITS-1:0]     req_key,
   input  logic [skvt_pkg::VALUE_FIELD_BITS-1:0]   req_value,
   input  logic [skvt_pkg::INDEX_FIELD_BITS-1:0]   req_index,
   output logic                                    ready,
   output logic                                    done,
   input  logic                                    taken,
   output skvt_pkg::result_type                    result,
   output skvt_pkg::ram_req_type                   ram_req,
   input  skvt_pkg::entry_type                     ram_rd_data
);
   import skvt_pkg::*;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [INDEX_FIELD_BITS-1:0] index_ff, index_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    ptr_ff, ptr_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic [ADDR_BITS-1:0]   chk_addr_ff, chk_addr_in;
   logic [ADDR_BITS-1:0]   slot_ff, slot_in;
   logic                   res_ok_ff, res_ok_in;
   logic [KEY_BITS-1:0]    res_key_ff, res_key_in;
   logic [VALUE_BITS-1:0]  res_value_ff, res_value_in;

   logic match;
   logic issue;
   logic full;
   logic index_hit;

   assign match     = chk_valid_ff && (ram_rd_data.key == key_ff);
   assign issue     = ptr_ff < count_ff;
   assign full      = (32'(count_ff) == CAPACITY);
   assign index_hit = 32'(index_ff) < 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      index_ff     <= index_in;
      ptr_ff       <= ptr_in;
      chk_addr_ff  <= chk_addr_in;
      slot_ff      <= slot_in;
      res_ok_ff    <= res_ok_in;
      res_key_ff   <= res_key_in;
      res_value_ff <= res_value_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_command)
                  CMD_INSERT, CMD_UPDATE, CMD_UPSERT, CMD_ERASE, CMD_GET_KEY:
                     state_in = ST_SEARCH;
                  CMD_GET_INDEX: state_in = ST_INDEX_CAP;
                  default:       state_in = ST_DONE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (match) begin
               state_in = (cmd_ff == CMD_ERASE) ? ST_ERASE_WR : ST_DONE;
            end else if (!issue) begin
               state_in = ST_DONE;
            end
         end
         ST_ERASE_WR:  state_in = ST_DONE;
         ST_INDEX_CAP: state_in = ST_DONE;
         ST_DONE: begin
            if (taken) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      slot_in      = slot_ff;
      res_ok_in    = res_ok_ff;
      res_key_in   = res_key_ff;
      res_value_in = res_value_ff;
      ram_req      = '0;
      ready        = 1'b0;
      done         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               cmd_in       = cmd_type'(req_command);
               key_in       = req_key[KEY_BITS-1:0];
               value_in     = req_value[VALUE_BITS-1:0];
               index_in     = req_index;
               ptr_in       = '0;
               res_ok_in    = 1'b0;
               res_key_in   = '0;
               res_value_in = '0;
               if (req_command == CMD_GET_INDEX) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = ADDR_BITS'(req_index);
               end
            end
         end
         ST_SEARCH: begin
            if (match) begin
               case (cmd_ff)
                  CMD_UPDATE, CMD_UPSERT: begin
                     ram_req.wr_en         = 1'b1;
                     ram_req.wr_addr       = chk_addr_ff;
                     ram_req.wr_data.key   = key_ff;
                     ram_req.wr_data.value = value_ff;
                     res_ok_in             = 1'b1;
                  end
                  CMD_ERASE: begin
                     // fetch the last pair to fill the hole
                     slot_in         = chk_addr_ff;
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = ADDR_BITS'(count_ff - 1'b1);
                  end
                  CMD_GET_KEY: begin
                     res_ok_in    = 1'b1;
                     res_value_in = ram_rd_data.value;
                  end
                  default: res_ok_in = 1'b0;
               endcase
            end else if (!issue) begin
               if ((cmd_ff == CMD_INSERT || cmd_ff == CMD_UPSERT) && !full) begin
                  ram_req.wr_en         = 1'b1;
                  ram_req.wr_addr       = ADDR_BITS'(count_ff);
                  ram_req.wr_data.key   = key_ff;
                  ram_req.wr_data.value = value_ff;
                  count_in              = count_ff + 1'b1;
                  res_ok_in             = 1'b1;
               end
            end else begin
               // advance the read pointer, compare in the next cycle
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ptr_ff[ADDR_BITS-1:0];
               ptr_in          = ptr_ff + 1'b1;
               chk_valid_in    = 1'b1;
               chk_addr_in     = ptr_ff[ADDR_BITS-1:0];
            end
         end
         ST_ERASE_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = slot_ff;
            ram_req.wr_data = ram_rd_data;
            count_in        = count_ff - 1'b1;
            res_ok_in       = 1'b1;
         end
         ST_INDEX_CAP: begin
            if (index_hit) begin
               res_ok_in    = 1'b1;
               res_key_in   = ram_rd_data.key;
               res_value_in = ram_rd_data.value;
            end
         end
         ST_DONE: done = 1'b1;
         default: ready = 1'b0;
      endcase
   end

   assign result.ok        = res_ok_ff;
   assign result.key_out   = KEY_FIELD_BITS'(res_key_ff);
   assign result.value_out = VALUE_FIELD_BITS'(res_value_ff);
   assign result.count     = COUNT_FIELD_BITS'(count_ff);

endmodule

### hdl/small_key_value_table.sv
// Get by index reads the slot on accept and captures it; key commands search the
// slots below the count, and erase then writes the last pair into the hole.
// One command at a time; the linear search reads one slot per cycle from the
// single read port of the slot RAM.
// Reset clears the entry count and both handshakes; slot contents are left as they
// are and only data from slots below the count is ever used, so no clearing pass is run.
module small_key_value_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [skvt_pkg::CMD_FIELD_BITS-1:0]   req_command,
   input  logic [skvt_pkg::KEY_FIELD_BITS-1:0]   req_key,
   input  logic [skvt_pkg::VALUE_FIELD_BITS-1:0] req_value,
   input  logic [skvt_pkg::INDEX_FIELD_BITS-1:0] req_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_ok,
   output logic [skvt_pkg::KEY_FIELD_BITS-1:0]   rsp_key_out,
   output logic [skvt_pkg::VALUE_FIELD_BITS-1:0] rsp_value_out,
   output logic [skvt_pkg::COUNT_FIELD_BITS-1:0] rsp_count
);
   import skvt_pkg::*;

   logic        ctrl_ready;
   logic        ctrl_done;
   logic        load;
   logic        start;
   result_type  result;
   ram_req_type ram_req;
   entry_type   ram_rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign req_ready = ctrl_ready;
   assign start     = req_valid && ctrl_ready;

   // hand the result over whenever the output register is free or draining
   assign load = ctrl_done && (!rsp_valid_ff || rsp_ready);

   skvt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .req_key     (req_key),
      .req_value   (req_value),
      .req_index   (req_index),
      .ready       (ctrl_ready),
      .done        (ctrl_done),
      .taken       (load),
      .result      (result),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   skvt_ram #(
      .WIDTH     ($bits(entry_type)),
      .DEPTH     (CAPACITY),
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ff.ok;
   assign rsp_key_out   = rsp_ff.key_out;
   assign rsp_value_out = rsp_ff.value_out;
   assign rsp_count     = rsp_ff.count;

endmodule
